>>> sv/rdstxt_pkg.sv
package rdstxt_pkg;

    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int MAX_CHARS   = 3;
    localparam int CNT_W       = 2;
    localparam int QUEUE_DEPTH = 2;

    // Printable pass-through range.
    localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7D;

    // Code-table selector bytes.
    localparam logic [BYTE_W-1:0] SEL_TAB0 = 8'h0F;
    localparam logic [BYTE_W-1:0] SEL_TAB1 = 8'h0E;
    localparam logic [BYTE_W-1:0] SEL_ESC  = 8'h1B;
    localparam logic [BYTE_W-1:0] SEL_ESC2 = 8'h6E;

    // Expanding codes.
    localparam logic [BYTE_W-1:0] CODE_SZ  = 8'h8D;
    localparam logic [BYTE_W-1:0] CODE_AE  = 8'h91;
    localparam logic [BYTE_W-1:0] CODE_OE  = 8'h97;
    localparam logic [BYTE_W-1:0] CODE_UE  = 8'h99;
    localparam logic [BYTE_W-1:0] CODE_CAE = 8'hD1;
    localparam logic [BYTE_W-1:0] CODE_COE = 8'hD7;
    localparam logic [BYTE_W-1:0] CODE_CUE = 8'hD9;

    localparam logic [CHAR_W-1:0] CH_QUEST = 7'h3F;
    localparam logic [CHAR_W-1:0] CH_LC_S  = 7'h73;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LC_O  = 7'h6F;
    localparam logic [CHAR_W-1:0] CH_LC_U  = 7'h75;
    localparam logic [CHAR_W-1:0] CH_LC_E  = 7'h65;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UC_O  = 7'h4F;
    localparam logic [CHAR_W-1:0] CH_UC_U  = 7'h55;

    // One decoded input byte: up to three characters, oldest in slot 0.
    typedef struct packed {
        logic [CNT_W-1:0]                    count;
        logic [MAX_CHARS-1:0][CHAR_W-1:0]    chars;
    } char_cmd_t;

    typedef struct packed {
        logic table_sel;
        logic held_valid;
    } front_status_t;

endpackage

>>> sv/rdstxt_front.sv
module rdstxt_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [rdstxt_pkg::BYTE_W-1:0]     char_byte,
    input  logic                              string_end,
    output logic                              cmd_valid,
    output rdstxt_pkg::char_cmd_t             cmd,
    output rdstxt_pkg::front_status_t         status
);

    logic                            table_sel_reg;
    logic                            table_sel_next;
    logic [rdstxt_pkg::BYTE_W-1:0]   held_escape_reg;
    logic [rdstxt_pkg::BYTE_W-1:0]   held_escape_next;
    logic                            held_valid_reg;
    logic                            held_valid_next;

    logic                            pair_hit;
    logic                            pair_tab;
    logic                            prefix;
    logic                            use_plain;
    logic                            hold;
    logic [rdstxt_pkg::CNT_W-1:0]    plain_n;
    logic [rdstxt_pkg::CHAR_W-1:0]   p0;
    logic [rdstxt_pkg::CHAR_W-1:0]   p1;
    logic [rdstxt_pkg::CNT_W-1:0]    total_n;

    always_comb
    begin
        pair_hit = 1'b0;
        pair_tab = table_sel_reg;
        if (held_valid_reg)
        begin
            if (held_escape_reg == rdstxt_pkg::SEL_TAB0 && char_byte == rdstxt_pkg::SEL_TAB0)
            begin
                pair_hit = 1'b1;
                pair_tab = 1'b0;
            end
            else if (held_escape_reg == rdstxt_pkg::SEL_TAB1
                     && char_byte == rdstxt_pkg::SEL_TAB1)
            begin
                pair_hit = 1'b1;
                pair_tab = 1'b1;
            end
            else if (held_escape_reg == rdstxt_pkg::SEL_ESC
                     && char_byte == rdstxt_pkg::SEL_ESC2)
            begin
                pair_hit = 1'b1;
                pair_tab = 1'b1;
            end
        end
        prefix    = held_valid_reg && !pair_hit;
        use_plain = !pair_hit;
    end

    // Classification of the byte as if nothing were held.
    always_comb
    begin
        hold    = 1'b0;
        plain_n = 2'd1;
        p0      = rdstxt_pkg::CH_QUEST;
        p1      = rdstxt_pkg::CH_QUEST;
        if (char_byte >= rdstxt_pkg::PRINT_LO && char_byte <= rdstxt_pkg::PRINT_HI)
        begin
            p0 = char_byte[rdstxt_pkg::CHAR_W-1:0];
        end
        else if (char_byte inside {rdstxt_pkg::SEL_TAB0, rdstxt_pkg::SEL_TAB1,
                                   rdstxt_pkg::SEL_ESC} && !string_end)
        begin
            hold    = 1'b1;
            plain_n = 2'd0;
        end
        else
        begin
            case (char_byte)
                rdstxt_pkg::CODE_SZ:
                begin
                    plain_n = 2'd2; p0 = rdstxt_pkg::CH_LC_S; p1 = rdstxt_pkg::CH_LC_S;
                end
                rdstxt_pkg::CODE_AE:
                begin
                    plain_n = 2'd2; p0 = rdstxt_pkg::CH_LC_A; p1 = rdstxt_pkg::CH_LC_E;
                end
                rdstxt_pkg::CODE_OE:
                begin
                    plain_n = 2'd2; p0 = rdstxt_pkg::CH_LC_O; p1 = rdstxt_pkg::CH_LC_E;
                end
                rdstxt_pkg::CODE_UE:
                begin
                    plain_n = 2'd2; p0 = rdstxt_pkg::CH_LC_U; p1 = rdstxt_pkg::CH_LC_E;
                end
                rdstxt_pkg::CODE_CAE:
                begin
                    if (!table_sel_reg)
                    begin
                        plain_n = 2'd2; p0 = rdstxt_pkg::CH_UC_A; p1 = rdstxt_pkg::CH_LC_E;
                    end
                end
                rdstxt_pkg::CODE_COE:
                begin
                    if (!table_sel_reg)
                    begin
                        plain_n = 2'd2; p0 = rdstxt_pkg::CH_UC_O; p1 = rdstxt_pkg::CH_LC_E;
                    end
                end
                rdstxt_pkg::CODE_CUE:
                begin
                    if (!table_sel_reg)
                    begin
                        plain_n = 2'd2; p0 = rdstxt_pkg::CH_UC_U; p1 = rdstxt_pkg::CH_LC_E;
                    end
                end
                default:
                begin
                    plain_n = 2'd1;
                end
            endcase
        end
    end

    // A held byte that found no partner becomes a leading '?'.
    always_comb
    begin
        total_n = {1'b0, prefix} + (use_plain ? plain_n : 2'd0);
        cmd.count = total_n;
        if (prefix)
        begin
            cmd.chars[0] = rdstxt_pkg::CH_QUEST;
            cmd.chars[1] = p0;
            cmd.chars[2] = p1;
        end
        else
        begin
            cmd.chars[0] = p0;
            cmd.chars[1] = p1;
            cmd.chars[2] = rdstxt_pkg::CH_QUEST;
        end
        cmd_valid = accept && (total_n != 2'd0);
    end

    always_comb
    begin
        table_sel_next   = table_sel_reg;
        held_escape_next = held_escape_reg;
        held_valid_next  = held_valid_reg;
        if (accept)
        begin
            if (string_end)
            begin
                table_sel_next   = 1'b0;
                held_escape_next = '0;
                held_valid_next  = 1'b0;
            end
            else
            begin
                table_sel_next  = pair_tab;
                held_valid_next = use_plain && hold;
                if (use_plain && hold)
                begin
                    held_escape_next = char_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_sel_reg   <= 1'b0;
            held_escape_reg <= '0;
            held_valid_reg  <= 1'b0;
        end
        else
        begin
            table_sel_reg   <= table_sel_next;
            held_escape_reg <= held_escape_next;
            held_valid_reg  <= held_valid_next;
        end
    end

    assign status.table_sel  = table_sel_reg;
    assign status.held_valid = held_valid_reg;

endmodule

>>> sv/rdstxt_queue.sv
module rdstxt_queue
#(
    parameter int DEPTH = rdstxt_pkg::QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  rdstxt_pkg::char_cmd_t     wr_data,
    input  logic                      rd_en,
    output rdstxt_pkg::char_cmd_t     rd_data,
    output logic                      full,
    output logic                      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rdstxt_pkg::char_cmd_t   entries_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    do_wr;
    logic                    do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/rdstxt_back.sv
module rdstxt_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  rdstxt_pkg::char_cmd_t             head,
    output logic                              head_done,
    output logic                              empty,
    input  logic                              pop,
    output logic [rdstxt_pkg::CHAR_W-1:0]     out_char,
    output logic                              run_last
);

    logic [rdstxt_pkg::CNT_W-1:0] idx_reg;
    logic [rdstxt_pkg::CNT_W-1:0] idx_next;
    logic                         take;

    assign empty    = !head_valid;
    assign run_last = (idx_reg == head.count - 1'b1);
    assign take     = pop && head_valid;
    // The queue entry retires with the beat of its last character.
    assign head_done = take && run_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_char = head.chars[0];
            2'd1:    out_char = head.chars[1];
            2'd2:    out_char = head.chars[2];
            default: out_char = rdstxt_pkg::CH_QUEST;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = run_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> sv/rds_text_to_ascii_transliterator.sv
// Broadcast text to display character converter.
//
// Input channel: char_byte with string_end is one beat, taken when push is
// high and full is low. Output channel: out_char with run_last is the oldest
// waiting character while empty is low; it is taken when pop is high.
// run_last marks the final character produced by one input byte.
//
// One input byte yields zero to three characters. A byte is decoded in the
// cycle it is taken and its characters are written into a small command
// queue. The output side drains one character per cycle while pop is high,
// and the input side keeps taking bytes back to back while the queue has room
// (QUEUE_DEPTH decoded bytes).
//
// Reset selects code table 0, drops any held selector byte and empties the
// queue. When the receiver stalls, characters wait in the queue and full
// rises once it fills; nothing is lost.
module rds_text_to_ascii_transliterator
#(
    parameter int QUEUE_DEPTH = rdstxt_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rdstxt_pkg::BYTE_W-1:0]     char_byte,
    input  logic                              string_end,
    output logic                              empty,
    input  logic                              pop,
    output logic [rdstxt_pkg::CHAR_W-1:0]     out_char,
    output logic                              run_last
);

    logic                         accept;
    logic                         cmd_valid;
    rdstxt_pkg::char_cmd_t        cmd;
    rdstxt_pkg::char_cmd_t        head;
    rdstxt_pkg::front_status_t    status;
    logic                         q_empty;
    logic                         head_done;

    assign accept = push && !full;

    rdstxt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_byte  (char_byte),
        .string_end (string_end),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .status     (status)
    );

    rdstxt_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (head_done),
        .rd_data (head),
        .full    (full),
        .empty   (q_empty)
    );

    rdstxt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_empty),
        .head       (head),
        .head_done  (head_done),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .run_last   (run_last)
    );

`ifndef SYNTH
    a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_char >= 7'h20 && out_char <= 7'h7D))
        else $error("output character outside the printable range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && string_end) |=> (!status.table_sel && !status.held_valid))
        else $error("table or held byte survived the end of a string");

    a_printable_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !status.held_valid && char_byte >= 8'h20 && char_byte <= 8'h7D)
            |=> !empty)
        else $error("printable byte produced no character");
`endif

endmodule

>>> tb/rds_text_checker.sv
`timescale 1ns / 100ps

module rds_text_checker
    import rdstxt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [BYTE_W-1:0] char_byte,
    input  logic              string_end,
    input  logic              empty,
    input  logic              pop,
    input  logic [CHAR_W-1:0] out_char,
    input  logic              run_last,
    output int                fail_count,
    output int                chars_waiting,
    output int                chars_checked,
    output int                table_switches
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } disp_char_t;

    disp_char_t char_q[$];

    // Shadow of the converter state.
    logic              table_sel = 1'b0;
    logic [BYTE_W-1:0] esc_byte  = '0;
    logic              esc_held  = 1'b0;
    int                step_chars;

    task automatic add_char(input logic [CHAR_W-1:0] c);
        char_q.push_back('{ch: c, last: 1'b0});
        step_chars++;
    endtask

    task automatic add_pair(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b);
        add_char(a);
        add_char(b);
    endtask

    // Decodes one byte with no selector byte held.
    task automatic decode_plain(input logic [BYTE_W-1:0] b, input logic at_end);
        if (b >= PRINT_LO && b <= PRINT_HI)
            add_char(b[CHAR_W-1:0]);
        else if (!at_end && (b == SEL_TAB0 || b == SEL_TAB1 || b == SEL_ESC))
        begin
            esc_byte = b;
            esc_held = 1'b1;
        end
        else
        begin
            case (b)
                CODE_SZ:  add_pair(CH_LC_S, CH_LC_S);
                CODE_AE:  add_pair(CH_LC_A, CH_LC_E);
                CODE_OE:  add_pair(CH_LC_O, CH_LC_E);
                CODE_UE:  add_pair(CH_LC_U, CH_LC_E);
                CODE_CAE: if (!table_sel) add_pair(CH_UC_A, CH_LC_E); else add_char(CH_QUEST);
                CODE_COE: if (!table_sel) add_pair(CH_UC_O, CH_LC_E); else add_char(CH_QUEST);
                CODE_CUE: if (!table_sel) add_pair(CH_UC_U, CH_LC_E); else add_char(CH_QUEST);
                default:  add_char(CH_QUEST);
            endcase
        end
    endtask

    task automatic predict_beat(input logic [BYTE_W-1:0] b, input logic at_end);
        disp_char_t tail;
        step_chars = 0;
        if (esc_held)
        begin
            esc_held = 1'b0;
            if (esc_byte == SEL_TAB0 && b == SEL_TAB0)
            begin
                table_sel = 1'b0;
                table_switches++;
            end
            else if ((esc_byte == SEL_TAB1 && b == SEL_TAB1) ||
                     (esc_byte == SEL_ESC && b == SEL_ESC2))
            begin
                table_sel = 1'b1;
                table_switches++;
            end
            else
            begin
                // The held byte had no partner, so it turns into a question mark.
                add_char(CH_QUEST);
                decode_plain(b, at_end);
            end
        end
        else
            decode_plain(b, at_end);

        if (at_end)
        begin
            table_sel = 1'b0;
            esc_held  = 1'b0;
            esc_byte  = '0;
        end

        if (step_chars > 0)
        begin
            tail = char_q.pop_back();
            tail.last = 1'b1;
            char_q.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        disp_char_t want;
        if (!rst_n)
        begin
            char_q.delete();
            table_sel = 1'b0;
            esc_byte  = '0;
            esc_held  = 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (char_q.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual %h run_last %b",
                             $time, out_char, run_last);
                    fail_count++;
                end
                else
                begin
                    want = char_q.pop_front();
                    chars_checked++;
                    if (out_char !== want.ch)
                    begin
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.ch, out_char);
                        fail_count++;
                    end
                    if (run_last !== want.last)
                    begin
                        $display("%0t: run_last mismatch: expected %b, actual %b",
                                 $time, want.last, run_last);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                predict_beat(char_byte, string_end);
        end
        chars_waiting = char_q.size();
    end

endmodule

>>> tb/tb_rds_text_to_ascii_transliterator.sv
`timescale 1ns / 100ps

module tb_rds_text_to_ascii_transliterator;

    import rdstxt_pkg::*;

    localparam int RAND_ITEMS  = 210;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        POP_STEADY,
        POP_COIN,
        POP_SPARSE,
        POP_PERIODIC
    } pop_mode_e;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              push       = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] char_byte  = '0;
    logic              string_end = 1'b0;
    logic              empty;
    logic              pop        = 1'b0;
    logic [CHAR_W-1:0] out_char;
    logic              run_last;

    int fail_count;
    int chars_waiting;
    int chars_checked;
    int table_switches;

    int bytes_sent   = 0;
    int strings_sent = 0;
    int burst_left   = 0;
    int cycle_cnt    = 0;

    pop_mode_e pop_mode = POP_STEADY;
    int        mode_cnt = 0;

    logic [BYTE_W-1:0] expand_codes [7] = '{CODE_SZ, CODE_AE, CODE_OE, CODE_UE,
                                           CODE_CAE, CODE_COE, CODE_CUE};
    logic [BYTE_W-1:0] sel_first    [3] = '{SEL_TAB0, SEL_TAB1, SEL_ESC};
    logic [BYTE_W-1:0] sel_second   [3] = '{SEL_TAB0, SEL_TAB1, SEL_ESC2};

    rds_text_to_ascii_transliterator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_byte  (char_byte),
        .string_end (string_end),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .run_last   (run_last)
    );

    rds_text_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_byte      (char_byte),
        .string_end     (string_end),
        .empty          (empty),
        .pop            (pop),
        .out_char       (out_char),
        .run_last       (run_last),
        .fail_count     (fail_count),
        .chars_waiting  (chars_waiting),
        .chars_checked  (chars_checked),
        .table_switches (table_switches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver switches at random between pop patterns.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_mode <= POP_STEADY;
            mode_cnt <= 0;
        end
        else
        begin
            if (mode_cnt == 0)
            begin
                pop_mode <= pop_mode_e'($urandom_range(0, 3));
                mode_cnt <= $urandom_range(16, 80);
            end
            else
                mode_cnt <= mode_cnt - 1;
            case (pop_mode)
                POP_STEADY:   pop <= 1'b1;
                POP_COIN:     pop <= 1'($urandom_range(0, 1));
                POP_SPARSE:   pop <= ($urandom_range(0, 7) == 0);
                POP_PERIODIC: pop <= (mode_cnt[2:0] > 2);
                default:      pop <= 1'b1;
            endcase
        end
    end

    // Sends one beat, opening a random gap whenever the current burst runs out.
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic e);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 12);
        end
        push       <= 1'b1;
        char_byte  <= b;
        string_end <= e;
        do @(posedge clk); while (full);
        burst_left--;
        bytes_sent++;
        if (e)
            strings_sent++;
    endtask

    // Holds the sender off until every predicted character has been taken.
    task automatic drain_results;
        push <= 1'b0;
        @(negedge clk);
        while (chars_waiting != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int  str_len;
        int  kind;
        int  idx;
        int  rand_start;
        bit  noisy;
        bit  paused;
        logic last;

        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(PRINT_LO, 1'b0);
        send_beat(PRINT_HI, 1'b0);
        send_beat(8'h1F, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CODE_SZ, 1'b0);
        send_beat(CODE_AE, 1'b0);
        send_beat(CODE_OE, 1'b0);
        send_beat(CODE_UE, 1'b0);
        send_beat(CODE_CAE, 1'b0);
        send_beat(CODE_COE, 1'b0);
        send_beat(CODE_CUE, 1'b0);
        // Upper-case umlauts are not expanded once table 1 is active.
        send_beat(SEL_TAB1, 1'b0);
        send_beat(SEL_TAB1, 1'b0);
        send_beat(CODE_CAE, 1'b0);
        // An escape without its partner, where the next byte starts a pair itself.
        send_beat(SEL_ESC, 1'b0);
        send_beat(SEL_TAB0, 1'b0);
        send_beat(SEL_TAB0, 1'b0);
        send_beat(SEL_ESC, 1'b0);
        send_beat(SEL_ESC2, 1'b0);
        send_beat(CODE_CUE, 1'b1);
        // The end of the string has put the table back to 0.
        send_beat(CODE_COE, 1'b0);
        send_beat(SEL_TAB0, 1'b1);
        send_beat(SEL_TAB1, 1'b0);
        send_beat(PRINT_LO, 1'b1);

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_ITEMS)
        begin
            if (!paused && bytes_sent - rand_start > RAND_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            str_len = $urandom_range(1, 14);
            noisy   = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < str_len; i++)
            begin
                last = (i == str_len - 1);
                kind = $urandom_range(0, 99);
                if (noisy)
                    send_beat(8'($urandom), 1'($urandom_range(0, 1)));
                else if (kind < 8)
                    send_beat(8'($urandom), last);
                else if (kind < 60)
                    send_beat(8'($urandom_range(PRINT_LO, PRINT_HI)), last);
                else if (kind < 80)
                    send_beat(expand_codes[$urandom_range(0, 6)], last);
                else if (kind < 92)
                begin
                    idx = $urandom_range(0, 2);
                    send_beat(sel_first[idx], 1'b0);
                    send_beat(sel_second[idx], last);
                end
                else
                    send_beat(sel_first[$urandom_range(0, 2)], last);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        @(negedge clk);

        $display("Sent %0d bytes in %0d marked strings, checked %0d characters.",
                 bytes_sent, strings_sent, chars_checked);
        $display("Code-table switches seen: %0d, under bursty input and varied pop patterns.",
                 table_switches);
        if (fail_count == 0 && chars_waiting == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            if (chars_waiting != 0)
                $display("%0t: %0d expected characters never arrived", $time, chars_waiting);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/rdstxt_pkg.sv
sv/rdstxt_front.sv
sv/rdstxt_queue.sv
sv/rdstxt_back.sv
sv/rds_text_to_ascii_transliterator.sv
tb/rds_text_checker.sv
tb/tb_rds_text_to_ascii_transliterator.sv
